FILE: hdl/scc_pkg.sv
// Shared types, constants and the CRC8 byte update for the scratchpad check.
// No dependencies; used by scc_frame and the top level.
package scc_pkg;

	localparam int unsigned FrameLen = 9;
	localparam int unsigned IdxW = 4;
	localparam logic [7:0] CrcPoly = 8'h8C;
	localparam logic [7:0] ByteOnes = 8'hFF;
	localparam logic [7:0] ByteZeros = 8'h00;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameLen - 1);

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FAULT    = 2'd1,
		STATUS_MISMATCH = 2'd2
	} status_t;

	// Verdict for one frame, produced on its last byte
	typedef struct packed {
		logic        last;
		status_t     status;
		logic [15:0] temp;
	} frame_res_t;

	// Reflected 1-Wire CRC8, one byte, LSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] crc;
		logic [7:0] d;
		logic       fb;
		crc = crc_in;
		d = b;
		for (int k = 0; k < 8; k++) begin
			fb = crc[0] ^ d[0];
			crc = crc >> 1;
			if (fb) begin
				crc = crc ^ CrcPoly;
			end
			d = d >> 1;
		end
		return crc;
	endfunction

endpackage

FILE: hdl/scc_temp_conv.sv
// Raw sensor value to hundredths of a degree: raw*100/16, truncated toward zero.
// Depends on nothing but its ports.
module scc_temp_conv (
	input  logic [15:0] raw,
	output logic [15:0] centi
);

	logic signed [23:0] raw_x;
	logic signed [23:0] prod;
	logic signed [23:0] adj;
	logic signed [23:0] quo;

	// raw*100 as shifts and adds (64 + 32 + 4)
	always_comb begin
		raw_x = 24'(signed'(raw));
		prod = (raw_x <<< 6) + (raw_x <<< 5) + (raw_x <<< 2);
		// bias negative values so the shift truncates toward zero
		adj = prod + (prod[23] ? 24'sd15 : 24'sd0);
		quo = adj >>> 4;
		centi = quo[15:0];
	end

endmodule

FILE: hdl/scc_frame.sv
// Frame state: byte count, running CRC, fault flags and temperature bytes.
// Depends on scc_pkg and scc_temp_conv.
module scc_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data,
	output scc_pkg::frame_res_t   res
);

	logic [scc_pkg::IdxW-1:0] idx_q;
	logic [7:0]               crc_q;
	logic                     ones_q;
	logic                     zeros_q;
	logic [7:0]               temp_low_q;
	logic [7:0]               temp_high_q;
	logic                     ones_nx;
	logic                     zeros_nx;
	logic [15:0]              centi;

	assign ones_nx = ones_q & (data == scc_pkg::ByteOnes);
	assign zeros_nx = zeros_q & (data == scc_pkg::ByteZeros);

	scc_temp_conv u_conv (
		.raw   ({temp_high_q, temp_low_q}),
		.centi (centi)
	);

	// verdict for the byte on hand; valid only when last is set
	always_comb begin
		res.last = (idx_q >= scc_pkg::LastIdx);
		res.temp = 16'd0;
		priority if (ones_nx || zeros_nx) begin
			res.status = scc_pkg::STATUS_FAULT;
		end else if (crc_q != data) begin
			res.status = scc_pkg::STATUS_MISMATCH;
		end else begin
			res.status = scc_pkg::STATUS_OK;
			res.temp = centi;
		end
	end

	// accumulate bytes 0..7, clear after the CRC byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= '0;
			ones_q <= 1'b1;
			zeros_q <= 1'b1;
			temp_low_q <= '0;
			temp_high_q <= '0;
		end else if (step) begin
			if (res.last) begin
				idx_q <= '0;
				crc_q <= '0;
				ones_q <= 1'b1;
				zeros_q <= 1'b1;
				temp_low_q <= '0;
				temp_high_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
				crc_q <= scc_pkg::crc8_byte(crc_q, data);
				ones_q <= ones_nx;
				zeros_q <= zeros_nx;
				if (idx_q == '0) begin
					temp_low_q <= data;
				end
				if (idx_q == scc_pkg::IdxW'(1)) begin
					temp_high_q <= data;
				end
			end
		end
	end

endmodule

FILE: hdl/scratchpad_crc_temperature_check.sv
// Top level of the scratchpad CRC and temperature check.
// Depends on scc_pkg and scc_frame (which holds scc_temp_conv).
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------
//   data    | data_valid, data_stall  | data_byte[7:0]
//   result  | result_valid, result_stall | status[1:0], temperature_centi[15:0]
//
// One byte per cycle sustained unless a ninth byte waits behind a stalled
// result; a result passes the input register, then the result register.
// The input register frees whenever its byte moves on, so bytes keep flowing
// while a result waits; only a ninth byte behind a stalled result waits.
// Reset clears the frame state and both valid flags; nothing else needs it.
module scratchpad_crc_temperature_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [15:0] temperature_centi
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                advance;
	scc_pkg::frame_res_t res;

	scc_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.res    (res)
	);

	// the held byte moves on unless it ends a frame and the result slot is blocked
	assign advance = valid_s1 && (!res.last || !result_valid || !result_stall);
	assign data_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall && data_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && res.last) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.last) begin
			status <= res.status;
			temperature_centi <= res.temp;
		end
	end

	// a failed frame never reports a temperature
	a_fail_zero_temp : assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != scc_pkg::STATUS_OK) |-> (temperature_centi == 16'd0))
		else $error("nonzero temperature on a failed frame");

	// input is held back only while a byte is waiting in the input register
	a_stall_needs_byte : assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> valid_s1)
		else $error("data stalled with empty input register");

	// a finished frame always lands in the result register
	a_frame_result : assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.last) |=> result_valid)
		else $error("frame end lost its result");

	// no frame ends while an untaken result is held
	a_no_overwrite : assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> !(advance && res.last))
		else $error("result overwritten while stalled");

endmodule
